>>> rtl/core/tmpg_pkg.sv
// tmpg_pkg: shared constants for the text mode pixel generator
// operation codes, register indexes, beat layouts, colors and font geometry
// no dependencies
package tmpg_pkg;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_CELL_WR = 2'd0;
  localparam logic [1:0] OP_FONT_WR = 2'd1;
  localparam logic [1:0] OP_PIX_RD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ACC_SCOL = 2'd0;
  localparam logic [1:0] REG_ACC_SROW = 2'd1;
  localparam logic [1:0] REG_ACC_ECOL = 2'd2;
  localparam logic [1:0] REG_ACC_EROW = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int OP_W       = 2;

  // screen and font geometry
  localparam int CELL_W     = 6;
  localparam int FONT_DEPTH = 2048;
  localparam int FONT_AW    = 11;
  localparam int CODE_W     = 8;

  localparam logic [6:0] X_LAST = 7'd127;

  localparam logic [7:0]  CHAR_SPACE    = 8'h20;
  localparam logic [7:0]  FONT_BLANK    = 8'h00;
  localparam logic [15:0] COLOR_ACCENT  = 16'hFFFF;
  localparam logic [15:0] COLOR_GRAY    = 16'hD6BA;
  localparam logic [15:0] COLOR_REGULAR = 16'hC426;
  localparam logic [15:0] COLOR_OFF     = 16'h0000;

  // reciprocal of the cell width, exact for dividends below 128
  localparam logic [5:0] DIV6_MUL = 6'd43;

endpackage

>>> rtl/core/tmpg_ram.sv
// tmpg_ram: generic simple dual port ram, one write and one registered read
// used for the character cells and the font store; no dependencies
module tmpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/text_mode_pixel_generator.sv
// pixel read: one read at a time; the cell ram read is followed by the dependent
// font ram read, then the color state, which holds while the output beat is stalled
// cell and font writes: accepted back to back
// rst is synchronous: control and config registers clear, then a clearing pass
// fills the font ram with zero and the cell ram with spaces while s_tready is low
// depends on tmpg_pkg and tmpg_ram
module text_mode_pixel_generator
  import tmpg_pkg::*;
#(
  parameter int TEXT_ROWS = 8,
  parameter int TEXT_COLS = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // cell_row, cell_col, char_code, font_line, font_bits, pixel_x, pixel_y
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_color, out_x, out_y, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int CELL_DEPTH = TEXT_ROWS * TEXT_COLS;
  localparam int CAW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CELL  = 5'b00100,
    ST_FONT  = 5'b01000,
    ST_COLOR = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [4:0] acc_scol, acc_ecol;
  logic [2:0] acc_srow, acc_erow;

  logic [FONT_AW-1:0] clr_cnt;
  logic [6:0] px;
  logic [5:0] py;

  // input beat fields
  logic [2:0] in_crow;
  logic [4:0] in_ccol;
  logic [7:0] in_code;
  logic [2:0] in_fline;
  logic [7:0] in_fbits;
  logic [6:0] in_px;
  logic [5:0] in_py;
  logic       in_beat;

  assign in_crow  = s_tdata[2:0];
  assign in_ccol  = s_tdata[7:3];
  assign in_code  = s_tdata[15:8];
  assign in_fline = s_tdata[18:16];
  assign in_fbits = s_tdata[26:19];
  assign in_px    = s_tdata[33:27];
  assign in_py    = s_tdata[39:34];

  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;

  // ram ports
  logic                  cell_we;
  logic [CAW-1:0]        cell_waddr, cell_raddr;
  logic [CODE_W-1:0]     cell_wdata, cell_rdata;
  logic                  font_we;
  logic [FONT_AW-1:0]    font_waddr, font_raddr;
  logic [7:0]            font_wdata, font_rdata;

  tmpg_ram #(.WIDTH(CODE_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tmpg_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (font_wdata),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  // pixel to cell mapping
  logic [6:0]  xm;
  logic [12:0] div_prod;
  logic [4:0]  col;
  logic [6:0]  col_x6;
  logic [2:0]  sub;
  logic [2:0]  row;
  logic [2:0]  line;
  logic        margin, in_grid, lit, accent;
  logic [15:0] color;

  always_comb begin
    xm       = px - 7'd1;
    div_prod = 13'(xm) * 13'(DIV6_MUL);
    col      = div_prod[12:8];
    col_x6   = 7'(col) * 7'(CELL_W);
    sub      = 3'(xm - col_x6);
    row      = py[5:3];
    line     = py[2:0];
    margin   = (px == 7'd0) || (px == X_LAST);
    in_grid  = (int'(col) < TEXT_COLS) && (int'(row) < TEXT_ROWS);
    lit      = font_rdata[3'd7 - sub];
    accent   = (acc_scol != 5'd0) && (col >= acc_scol) && (col <= acc_ecol)
               && (row >= acc_srow) && (row <= acc_erow);
    if (margin || !in_grid || !lit) begin
      color = COLOR_OFF;
    end else if (row == 3'd0) begin
      color = COLOR_GRAY;
    end else if (accent) begin
      color = COLOR_ACCENT;
    end else begin
      color = COLOR_REGULAR;
    end
  end

  assign cell_raddr = CAW'(int'(row) * TEXT_COLS + int'(col));
  assign font_raddr = {cell_rdata, line};

  // write ports: clearing pass or a write beat
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = CAW'(int'(in_crow) * TEXT_COLS + int'(in_ccol));
    cell_wdata = in_code;
    font_we    = 1'b0;
    font_waddr = {in_code, in_fline};
    font_wdata = in_fbits;
    if (state == ST_CLEAR) begin
      cell_we    = int'(clr_cnt) < CELL_DEPTH;
      cell_waddr = clr_cnt[CAW-1:0];
      cell_wdata = CHAR_SPACE;
      font_we    = 1'b1;
      font_waddr = clr_cnt;
      font_wdata = FONT_BLANK;
    end else if (in_beat) begin
      cell_we = (s_tuser == OP_CELL_WR) && (int'(in_crow) < TEXT_ROWS)
                && (int'(in_ccol) < TEXT_COLS);
      font_we = (s_tuser == OP_FONT_WR);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == FONT_AW'(FONT_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_beat && s_tuser == OP_PIX_RD) state_next = ST_CELL;
      end
      ST_CELL:  state_next = ST_FONT;
      ST_FONT:  state_next = ST_COLOR;
      ST_COLOR: begin
        // hold here while the previous result is still waiting
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      acc_scol <= '0;
      acc_srow <= '0;
      acc_ecol <= '0;
      acc_erow <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ACC_SCOL: acc_scol <= cfg_data;
          REG_ACC_SROW: acc_srow <= cfg_data[2:0];
          REG_ACC_ECOL: acc_ecol <= cfg_data;
          REG_ACC_EROW: acc_erow <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (state == ST_COLOR && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && s_tuser == OP_PIX_RD) begin
      px <= in_px;
      py <= in_py;
    end
    if (state == ST_COLOR && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, py, px, color};
    end
  end

endmodule

>>> rtl/core/tmpg_checker.sv
// tmpg_checker: port level checks for text_mode_pixel_generator
// bound to the top level below; depends on tmpg_pkg
module tmpg_checker
  import tmpg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [OP_W-1:0]       s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output beat changed while stalled");

  // reset starts the clearing pass with nothing pending
  a_reset_busy: assert property (@(posedge clk)
    rst |=> (!s_tready && !m_tvalid))
    else $error("block not busy after reset");

  // a pixel read keeps the sequencer busy
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_PIX_RD) |=> !s_tready)
    else $error("input accepted during pixel read");

  // margin columns are always black
  a_margin_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[22:16] == 7'd0 || m_tdata[22:16] == X_LAST))
      |-> (m_tdata[15:0] == COLOR_OFF))
    else $error("margin pixel not black");

  // pad bits of the output beat stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:29] == 3'b000))
    else $error("output pad bits set");

endmodule

bind text_mode_pixel_generator tmpg_checker u_tmpg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/text_mode_pixel_checker.sv
// text_mode_pixel_checker: watches the config port and both stream channels,
// keeps its own copy of the cell and font stores and predicts every pixel beat
// depends on tmpg_pkg
module text_mode_pixel_checker
  import tmpg_pkg::*;
#(
  parameter int TEXT_ROWS = 8,
  parameter int TEXT_COLS = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]       s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    mismatches,
  output int                    pixels_due
);

  localparam int CELL_H = 8;

  typedef struct packed {
    logic [15:0] color;
    logic [6:0]  x;
    logic [5:0]  y;
  } pixel_beat_t;

  logic [7:0]  cells [TEXT_ROWS*TEXT_COLS];
  logic [7:0]  glyphs [FONT_DEPTH];
  logic [4:0]  acc_scol, acc_ecol;
  logic [2:0]  acc_srow, acc_erow;
  pixel_beat_t pixels_q [$];

  function automatic logic [15:0] pixel_color_of(logic [6:0] px, logic [5:0] py);
    int unsigned xi, col, sub, row, line, x0, x1, y0, y1;
    logic [7:0] bits;
    // left and right margin columns stay dark
    if (px == 7'd0 || px == X_LAST) return COLOR_OFF;
    xi = int'(px) - 1;
    col = xi / CELL_W;
    sub = xi % CELL_W;
    row = int'(py) / CELL_H;
    line = int'(py) % CELL_H;
    if (col >= TEXT_COLS || row >= TEXT_ROWS) return COLOR_OFF;
    bits = glyphs[int'(cells[row*TEXT_COLS + col])*CELL_H + line];
    if (bits[7-sub] == 1'b0) return COLOR_OFF;
    if (py < CELL_H) return COLOR_GRAY;
    if (acc_scol == 5'd0) return COLOR_REGULAR;
    x0 = 1 + int'(acc_scol)*CELL_W;
    x1 = (int'(acc_ecol) + 1)*CELL_W;
    y0 = int'(acc_srow)*CELL_H;
    y1 = (int'(acc_erow) + 1)*CELL_H - 1;
    if (px >= x0 && px <= x1 && py >= y0 && py <= y1) return COLOR_ACCENT;
    return COLOR_REGULAR;
  endfunction

  always @(posedge clk) begin : track
    logic [2:0]  crow, fline;
    logic [4:0]  ccol;
    logic [7:0]  code, fbits;
    logic [6:0]  px;
    logic [5:0]  py;
    pixel_beat_t want;
    if (rst) begin
      foreach (cells[i]) cells[i] = CHAR_SPACE;
      foreach (glyphs[i]) glyphs[i] = FONT_BLANK;
      acc_scol = '0;
      acc_srow = '0;
      acc_ecol = '0;
      acc_erow = '0;
      pixels_q.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pixels_q.size() == 0) begin
          $error("pixel beat with nothing expected: %h", m_tdata);
          mismatches++;
        end else begin
          want = pixels_q.pop_front();
          if (m_tdata[15:0] !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, m_tdata[15:0]);
            mismatches++;
          end
          if (m_tdata[22:16] !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, m_tdata[22:16]);
            mismatches++;
          end
          if (m_tdata[28:23] !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, m_tdata[28:23]);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ACC_SCOL: acc_scol = cfg_data[4:0];
          REG_ACC_SROW: acc_srow = cfg_data[2:0];
          REG_ACC_ECOL: acc_ecol = cfg_data[4:0];
          REG_ACC_EROW: acc_erow = cfg_data[2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        {py, px, fbits, fline, code, ccol, crow} = s_tdata;
        case (s_tuser)
          OP_CELL_WR: begin
            // writes outside the text grid are dropped
            if (crow < TEXT_ROWS && ccol < TEXT_COLS) cells[crow*TEXT_COLS + ccol] = code;
          end
          OP_FONT_WR: glyphs[{code, fline}] = fbits;
          OP_PIX_RD: begin
            want.color = pixel_color_of(px, py);
            want.x = px;
            want.y = py;
            pixels_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    // registered so the stimulus side never races the queue update
    pixels_due <= pixels_q.size();
  end

endmodule

>>> tb/sv/text_mode_pixel_generator_tb.sv
// text_mode_pixel_generator_tb: clock, reset and stimulus for the pixel generator,
// directed corner beats then random traffic over several accent box settings
// depends on tmpg_pkg, text_mode_pixel_generator and text_mode_pixel_checker
module text_mode_pixel_generator_tb;
  import tmpg_pkg::*;

  localparam int TEXT_ROWS = 8;
  localparam int TEXT_COLS = 21;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 6000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    mismatches;
  int                    pixels_due;
  bit                    steady = 1'b0;
  bit                    stall_rx = 1'b0;
  int unsigned           quiet = 0;

  text_mode_pixel_generator #(.TEXT_ROWS(TEXT_ROWS), .TEXT_COLS(TEXT_COLS)) dut (.*);

  text_mode_pixel_checker #(.TEXT_ROWS(TEXT_ROWS), .TEXT_COLS(TEXT_COLS)) chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no beat on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("[text_mode_pixel_generator] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side backpressure
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (stall_rx) begin
        stall_rx = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack(logic [2:0] crow, logic [4:0] ccol,
      logic [7:0] code, logic [2:0] fline, logic [7:0] fbits, logic [6:0] px,
      logic [5:0] py);
    return {py, px, fbits, fline, code, ccol, crow};
  endfunction

  // mostly a small set of codes so that glyphs get loaded and hit
  function automatic logic [7:0] pick_code();
    if ($urandom_range(9) < 3) return 8'($urandom);
    case ($urandom_range(7))
      0: return 8'h20;
      1: return 8'h00;
      2: return 8'hFF;
      3: return 8'h41;
      4: return 8'h7F;
      5: return 8'h80;
      6: return 8'h55;
      default: return 8'hAA;
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [IN_DATA_W-1:0] beat);
    while (!steady && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wr_cell(logic [2:0] crow, logic [4:0] ccol, logic [7:0] code);
    send(OP_CELL_WR, pack(crow, ccol, code, 3'd0, 8'd0, 7'd0, 6'd0));
  endtask

  task automatic wr_font(logic [7:0] code, logic [2:0] fline, logic [7:0] fbits);
    send(OP_FONT_WR, pack(3'd0, 5'd0, code, fline, fbits, 7'd0, 6'd0));
  endtask

  task automatic rd_pixel(logic [6:0] px, logic [5:0] py);
    send(OP_PIX_RD, pack(3'd0, 5'd0, 8'd0, 3'd0, 8'd0, px, py));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // row registers get junk in the unused upper bits
  task automatic set_accent(logic [4:0] scol, logic [2:0] srow, logic [4:0] ecol,
      logic [2:0] erow);
    cfg_write(REG_ACC_SCOL, scol);
    cfg_write(REG_ACC_SROW, {2'($urandom), srow});
    cfg_write(REG_ACC_ECOL, ecol);
    cfg_write(REG_ACC_EROW, {2'($urandom), erow});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_items(int count);
    int          done;
    int unsigned pick;
    logic [1:0]  op;
    logic [2:0]  crow, fline;
    logic [4:0]  ccol;
    logic [7:0]  code, fbits;
    logic [6:0]  px;
    logic [5:0]  py;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      crow = 3'($urandom);
      ccol = 5'($urandom);
      code = 8'($urandom);
      fline = 3'($urandom);
      fbits = 8'($urandom);
      px = 7'($urandom);
      py = 6'($urandom);
      if (pick < 25) begin
        op = OP_CELL_WR;
        ccol = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 21)) : 5'($urandom_range(20));
        code = pick_code();
      end else if (pick < 45) begin
        op = OP_FONT_WR;
        code = pick_code();
      end else if (pick < 96) begin
        op = OP_PIX_RD;
      end else begin
        op = OP_NONE;
      end
      send(op, pack(crow, ccol, code, fline, fbits, px, py));
      if (op != OP_NONE) done++;
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wr_font(8'h41, 3'd0, 8'hFF);
    wr_font(8'h41, 3'd7, 8'h81);
    wr_font(8'hFF, 3'd7, 8'hFF);
    wr_font(8'h00, 3'd3, 8'h5A);
    wr_cell(3'd0, 5'd0, 8'h41);
    wr_cell(3'd7, 5'd20, 8'hFF);
    wr_cell(3'd0, 5'd21, 8'hFF);     // just past the last column
    wr_cell(3'd3, 5'd31, 8'h41);
    wr_cell(3'd2, 5'd10, 8'h00);
    send(OP_NONE, IN_DATA_W'({$urandom, $urandom}));
    rd_pixel(7'd0, 6'd0);
    rd_pixel(7'd127, 6'd63);
    rd_pixel(7'd1, 6'd0);
    rd_pixel(7'd6, 6'd0);
    rd_pixel(7'd1, 6'd7);
    rd_pixel(7'd2, 6'd7);
    rd_pixel(7'd126, 6'd63);
    rd_pixel(7'd121, 6'd63);
    rd_pixel(7'd64, 6'd19);
    rd_pixel(7'd7, 6'd0);
    rd_pixel(7'd122, 6'd56);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_accent(5'd1, 3'd0, 5'd20, 3'd7);
        1: set_accent(5'd20, 3'd7, 5'd0, 3'd0);   // start past end, empty box
        2: set_accent(5'd0, 3'd1, 5'd10, 3'd5);   // accent off
        3: set_accent(5'd11, 3'd2, 5'd15, 3'd4);
        4: set_accent(5'd20, 3'd7, 5'd20, 3'd7);
        default: set_accent(5'($urandom_range(20)), 3'($urandom), 5'($urandom_range(20)),
                            3'($urandom));
      endcase
      steady = (p == 4);
      if (p == 1) stall_rx = 1'b1;
      if (p == 3) begin
        run_items(ITEMS_PER_PHASE / 2);
        drain();
        run_items(ITEMS_PER_PHASE / 2);
      end else begin
        run_items(ITEMS_PER_PHASE);
      end
      drain();
    end

    if (mismatches == 0 && pixels_due == 0) begin
      $display("[text_mode_pixel_generator] OK");
    end else begin
      $display("[text_mode_pixel_generator] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tmpg_pkg.sv
rtl/core/tmpg_ram.sv
rtl/core/text_mode_pixel_generator.sv
rtl/core/tmpg_checker.sv
tb/sv/text_mode_pixel_checker.sv
tb/sv/text_mode_pixel_generator_tb.sv
